### sv/urlf_pkg.sv
// Shared constants of the UART receive line buffer.
`default_nettype none
package urlf_pkg;

	localparam int DEFAULT_DEPTH = 32;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Request codes carried by req_type.
	localparam logic REQ_RX   = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Bit positions inside the sticky error vector.
	localparam int ERR_FRAME     = 0;
	localparam int ERR_OVERRUN   = 1;
	localparam int ERR_PARITY    = 2;
	localparam int ERR_RING_FULL = 3;
	localparam int ERR_W         = 4;

	typedef logic [ERR_W-1:0] err_vec_t;

endpackage
`default_nettype wire

### sv/urlf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module urlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/uart_rx_line_fifo.sv
// Top level of the UART receive ring buffer with text line handling.
// This block buffers received characters for software. A word with req_type 0
// is a character from the line with its framing, overrun and parity flags; a
// word with req_type 1 is a software read that pops one character. The ring
// holds at most DEPTH-1 characters. A character that arrives while the ring
// is full is dropped and only the sticky ring-full flag records it. CR and LF
// are stored as a zero byte that ends a line and raise line_ready, unless the
// character before was also CR or LF, in which case nothing is stored. Error
// flags are sticky: error_alarm reports after every receive whether any flag
// is set, and a read that pops a character returns the flags and clears them.
// A read of an empty ring returns no_data and keeps the flags. Every word gives
// exactly one result word. The block accepts one word per clock cycle while
// in_stall is low. An accepted word first updates the ring state and starts
// the registered read of the ring memory, together with the memory read stage,
// and then passes to the output register. in_stall rises only when both the
// memory read stage and the output register are full and the consumer stalls.
`default_nettype none
module uart_rx_line_fifo
	import urlf_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	// Request side.
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        req_type,
	input  wire  [7:0] rx_byte,
	input  wire        frame_error,
	input  wire        overrun_error,
	input  wire        parity_error,
	// Result side.
	output logic       out_valid,
	input  wire        out_stall,
	output logic       read_valid,
	output logic       no_data,
	output logic [7:0] read_byte,
	output logic       err_frame,
	output logic       err_overrun,
	output logic       err_parity,
	output logic       err_ring_full,
	output logic       line_ready,
	output logic       error_alarm
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// Ring state. The indices point at the last written and the last read slot.
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [7:0]       prev_byte_q;
	err_vec_t         sticky_q;

	// Memory read stage.
	logic             valid_s1;
	logic             pop_s1;
	logic             no_data_s1;
	err_vec_t         errs_s1;
	logic             line_s1;
	logic             alarm_s1;

	// Output register.
	logic             out_valid_q;

	logic             accept;
	logic             s1_go;
	logic             out_free;
	logic             is_rx;
	logic [IDX_W-1:0] wr_next;
	logic [IDX_W-1:0] rd_next;
	logic             ring_full;
	logic             ring_empty;
	logic             byte_term;
	logic             prev_term;
	logic             store;
	logic             pop;
	logic             line_evt;
	logic [7:0]       store_byte;
	err_vec_t         line_errs;
	err_vec_t         sticky_next;
	logic [7:0]       ram_rdata;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	assign is_rx   = (req_type == REQ_RX);
	assign wr_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;

	// The ring keeps one slot free so that full and empty differ.
	assign ring_full  = (wr_next == rd_idx_q);
	assign ring_empty = (wr_idx_q == rd_idx_q);

	assign byte_term = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign prev_term = (prev_byte_q == CH_CR) || (prev_byte_q == CH_LF);

	// A terminator right after another terminator is swallowed.
	assign store      = accept && is_rx && !ring_full && (!byte_term || !prev_term);
	assign line_evt   = is_rx && !ring_full && byte_term && !prev_term;
	assign store_byte = byte_term ? 8'h00 : rx_byte;
	assign pop        = accept && !is_rx && !ring_empty;

	// On a full ring the line flags of the dropped character are discarded.
	always_comb begin
		line_errs = '0;
		if (ring_full) begin
			line_errs[ERR_RING_FULL] = 1'b1;
		end else begin
			line_errs[ERR_FRAME]   = frame_error;
			line_errs[ERR_OVERRUN] = overrun_error;
			line_errs[ERR_PARITY]  = parity_error;
		end
	end

	assign sticky_next = sticky_q | line_errs;

	urlf_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (store),
		.waddr (wr_next),
		.wdata (store_byte),
		.re    (pop),
		.raddr (rd_next),
		.rdata (ram_rdata)
	);

	// Ring state update at the edge that accepts the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			prev_byte_q <= '0;
			sticky_q    <= '0;
		end else if (accept) begin
			if (is_rx) begin
				prev_byte_q <= rx_byte;
				sticky_q    <= sticky_next;
				if (store) begin
					wr_idx_q <= wr_next;
				end
			end else if (pop) begin
				rd_idx_q <= rd_next;
				sticky_q <= '0;
			end
		end
	end

	// Memory read stage: holds the result fields while the ring data is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_go) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1     <= pop;
			no_data_s1 <= !is_rx && ring_empty;
			errs_s1    <= pop ? sticky_q : '0;
			line_s1    <= line_evt;
			alarm_s1   <= is_rx && (sticky_next != '0);
		end
	end

	// Output register. The ring data stays stable while the stage waits,
	// because the memory is read only when a word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			read_valid    <= pop_s1;
			no_data       <= no_data_s1;
			read_byte     <= pop_s1 ? ram_rdata : 8'h00;
			err_frame     <= errs_s1[ERR_FRAME];
			err_overrun   <= errs_s1[ERR_OVERRUN];
			err_parity    <= errs_s1[ERR_PARITY];
			err_ring_full <= errs_s1[ERR_RING_FULL];
			line_ready    <= line_s1;
			error_alarm   <= alarm_s1;
		end
	end

	assign out_valid = out_valid_q;

	// A character offered to a full ring must not move the write index.
	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_rx && ring_full |=> wr_idx_q == $past(wr_idx_q))
		else $error("write index moved on a full ring");

	// A popped word never carries receive events or the empty mark.
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> !no_data && !line_ready && !error_alarm)
		else $error("pop result carries receive fields");

	// The input is held back only when both stages are occupied.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

	// A pop clears the sticky flags for the next word.
	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> sticky_q == '0)
		else $error("sticky flags survived a pop");

endmodule
`default_nettype wire
